### hdl/jrut_pkg.sv
// Shared types, codes and defaults for the joint range unwrap tracker.
package jrut_pkg;

    localparam int ARM_COUNT_DEF   = 2;
    localparam int MOTORS_EACH_DEF = 8;
    localparam int MAX_SAMPLES_DEF = 262144;

    // Stored sample count is wide enough for the largest allowed sample limit.
    localparam int CNT_W = 21;

    typedef enum logic [1:0] {
        KIND_SAMPLE = 2'd0,
        KIND_START  = 2'd1,
        KIND_STOP   = 2'd2,
        KIND_READ   = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STAT_LIVE     = 3'd0,
        STAT_SAMPLE   = 3'd1,
        STAT_STARTED  = 3'd2,
        STAT_IGNORED  = 3'd3,
        STAT_STOP_FEW = 3'd4,
        STAT_STOP_OK  = 3'd5,
        STAT_STOP_DBL = 3'd6,
        STAT_READ     = 3'd7
    } t_status;

    typedef enum logic {
        FSM_IDLE = 1'b0,
        FSM_EXEC = 1'b1
    } t_fsm;

    typedef struct packed {
        t_kind              kind;
        logic               arm_select;
        logic [2:0]         motor_select;
        logic signed [15:0] position_code;
    } t_in;

    typedef struct packed {
        t_status            status;
        logic signed [31:0] position;
        logic signed [31:0] minimum;
        logic signed [31:0] maximum;
        logic [31:0]        travel_len;
        logic [18:0]        sample_tally;
        logic signed [15:0] first_code;
        logic               recorded;
    } t_out;

    typedef struct packed {
        logic signed [31:0] minimum;
        logic signed [31:0] maximum;
        logic [31:0]        travel_len;
        logic [CNT_W-1:0]   sample_tally;
        logic signed [15:0] first_code;
        logic               recorded;
    } t_track;

endpackage

### hdl/jrut_track_mem.sv
// Track memory with one valid bit per entry; an entry not yet written reads as zero.
module jrut_track_mem #(
    parameter int TRACKS = 16,
    parameter int IDX_W  = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_rd_en,
    input  logic [IDX_W-1:0] i_rd_addr,
    output jrut_pkg::t_track o_rd_data,
    input  logic            i_wr_en,
    input  logic [IDX_W-1:0] i_wr_addr,
    input  jrut_pkg::t_track i_wr_data
);
    import jrut_pkg::*;

    t_track              mem [TRACKS];
    t_track              r_rd;
    logic                r_rd_ok;
    logic [TRACKS-1:0]   r_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd <= mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_ok <= r_valid[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd : '0;

endmodule

### hdl/joint_range_unwrap_tracker.sv
// Top level of the joint range unwrap tracker.
// Each beat is accepted only in the idle state: the accept cycle reads the addressed track
// from the track memory, and the execute state then updates it, writes it back and loads
// the result register, so no new beat is taken until the execute state completes; a full
// result register holds the execute state until it is taken. Track memory reads as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
module joint_range_unwrap_tracker #(
    parameter int ARM_COUNT   = jrut_pkg::ARM_COUNT_DEF,
    parameter int MOTORS_EACH = jrut_pkg::MOTORS_EACH_DEF,
    parameter int MAX_SAMPLES = jrut_pkg::MAX_SAMPLES_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  jrut_pkg::t_in i_in_data,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output jrut_pkg::t_out o_out_data
);
    import jrut_pkg::*;

    localparam int TRACKS = ARM_COUNT * MOTORS_EACH;
    localparam int IDX_W  = (TRACKS > 1) ? $clog2(TRACKS) : 1;

    t_fsm               r_state, n_state;
    t_in                r_item;
    logic [IDX_W-1:0]   r_addr;
    logic               r_sel_ok;
    logic               r_recording, n_recording;
    logic [IDX_W-1:0]   r_active, n_active;
    logic               r_seen_first, n_seen_first;
    logic signed [15:0] r_last_code, n_last_code;
    logic signed [31:0] r_last_unw, n_last_unw;
    logic               r_out_valid;
    t_out               r_out, n_out;

    logic               accept;
    logic               exec_fire;
    logic               sel_ok;
    logic [6:0]         sel_wide;
    logic [IDX_W-1:0]   rd_addr;
    t_track             rd_data;
    t_track             wr_data;
    logic               wr_req;

    logic signed [15:0] step;
    logic [32:0]        u_sum;
    logic signed [31:0] u_sat;
    logic [16:0]        step_abs;
    logic [32:0]        p_sum;
    logic [31:0]        p_sat;
    logic [32:0]        extent;
    logic [34:0]        extent3;
    logic [34:0]        twice;

    always_comb begin
        n_state = r_state;
        case (r_state)
            FSM_IDLE: begin
                if (accept) begin
                    n_state = FSM_EXEC;
                end
            end
            FSM_EXEC: begin
                if (exec_fire) begin
                    n_state = FSM_IDLE;
                end
            end
            default: n_state = FSM_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        exec_fire  = 1'b0;
        case (r_state)
            FSM_IDLE: o_in_ready = 1'b1;
            FSM_EXEC: exec_fire  = !r_out_valid || i_out_ready;
            default: begin
                o_in_ready = 1'b0;
                exec_fire  = 1'b0;
            end
        endcase
    end

    assign accept   = i_in_valid && o_in_ready;
    assign sel_ok   = (32'(i_in_data.arm_select) < ARM_COUNT) &&
                      (32'(i_in_data.motor_select) < MOTORS_EACH);
    assign sel_wide = 7'(i_in_data.arm_select) * 7'(MOTORS_EACH) +
                      7'(i_in_data.motor_select);
    assign rd_addr  = (i_in_data.kind == KIND_SAMPLE || i_in_data.kind == KIND_STOP) ?
                      r_active : sel_wide[IDX_W-1:0];

    jrut_track_mem #(
        .TRACKS (TRACKS),
        .IDX_W  (IDX_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_req && exec_fire),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_data)
    );

    assign step     = r_item.position_code - r_last_code;
    assign u_sum    = {r_last_unw[31], r_last_unw} + {{17{step[15]}}, step};
    assign u_sat    = (u_sum[32] != u_sum[31]) ?
                      (u_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : u_sum[31:0];
    assign step_abs = step[15] ? (17'd0 - {step[15], step}) : {1'b0, step};
    assign p_sum    = {1'b0, rd_data.travel_len} + 33'(step_abs);
    assign p_sat    = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    assign extent   = {rd_data.maximum[31], rd_data.maximum} -
                      {rd_data.minimum[31], rd_data.minimum};
    assign extent3  = {2'b00, extent} + {1'b0, extent, 1'b0};
    assign twice    = {2'b00, rd_data.travel_len, 1'b0};

    always_comb begin
        n_recording  = r_recording;
        n_active     = r_active;
        n_seen_first = r_seen_first;
        n_last_code  = r_last_code;
        n_last_unw   = r_last_unw;
        wr_data      = rd_data;
        wr_req       = 1'b0;
        n_out        = '0;
        n_out.status = STAT_IGNORED;
        case (r_item.kind)
            KIND_SAMPLE: begin
                if (!r_recording) begin
                    if (r_sel_ok) begin
                        n_out.status   = STAT_LIVE;
                        n_out.position = 32'(r_item.position_code);
                    end
                end else begin
                    if (!r_seen_first) begin
                        n_seen_first       = 1'b1;
                        n_last_unw         = 32'(r_item.position_code);
                        wr_data.first_code = r_item.position_code;
                        wr_data.minimum    = 32'(r_item.position_code);
                        wr_data.maximum    = 32'(r_item.position_code);
                    end else begin
                        n_last_unw         = u_sat;
                        wr_data.travel_len = p_sat;
                        if (u_sat < rd_data.minimum) begin
                            wr_data.minimum = u_sat;
                        end
                        if (u_sat > rd_data.maximum) begin
                            wr_data.maximum = u_sat;
                        end
                    end
                    if (32'(rd_data.sample_tally) < MAX_SAMPLES) begin
                        wr_data.sample_tally = rd_data.sample_tally + CNT_W'(1);
                    end
                    n_last_code    = r_item.position_code;
                    wr_req         = 1'b1;
                    n_out.status   = STAT_SAMPLE;
                    n_out.position = n_last_unw;
                end
            end
            KIND_START: begin
                if (!r_recording && r_sel_ok) begin
                    wr_data      = '0;
                    wr_req       = 1'b1;
                    n_active     = r_addr;
                    n_seen_first = 1'b0;
                    n_recording  = 1'b1;
                    n_out.status = STAT_STARTED;
                end
            end
            KIND_STOP: begin
                if (r_recording) begin
                    n_recording      = 1'b0;
                    wr_data.recorded = (rd_data.sample_tally > CNT_W'(1));
                    wr_req           = 1'b1;
                    if (!wr_data.recorded) begin
                        n_out.status = STAT_STOP_FEW;
                    end else if (twice > extent3) begin
                        n_out.status = STAT_STOP_DBL;
                    end else begin
                        n_out.status = STAT_STOP_OK;
                    end
                end
            end
            KIND_READ: begin
                if (r_sel_ok) begin
                    n_out.status = STAT_READ;
                end
            end
            default: n_out.status = STAT_IGNORED;
        endcase
        if (n_out.status != STAT_LIVE && n_out.status != STAT_IGNORED) begin
            n_out.minimum      = wr_data.minimum;
            n_out.maximum      = wr_data.maximum;
            n_out.travel_len   = wr_data.travel_len;
            n_out.sample_tally = wr_data.sample_tally[18:0];
            n_out.first_code   = wr_data.first_code;
            n_out.recorded     = wr_data.recorded;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= FSM_IDLE;
            r_recording  <= 1'b0;
            r_active     <= '0;
            r_seen_first <= 1'b0;
            r_last_code  <= '0;
            r_last_unw   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (exec_fire) begin
                r_recording  <= n_recording;
                r_active     <= n_active;
                r_seen_first <= n_seen_first;
                r_last_code  <= n_last_code;
                r_last_unw   <= n_last_unw;
                r_out_valid  <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item   <= i_in_data;
            r_addr   <= sel_ok || i_in_data.kind == KIND_SAMPLE ||
                        i_in_data.kind == KIND_STOP ? rd_addr : '0;
            r_sel_ok <= sel_ok;
        end
        if (exec_fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule
